### sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/arst_pkg.sv
// types, constants and opcodes of the address range set table
package arst_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 48;
  localparam int OP_W      = 3;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB      = 3'd2;
  localparam logic [OP_W-1:0] OP_TEST_VAL = 3'd3;
  localparam logic [OP_W-1:0] OP_TEST_RNG = 3'd4;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [ADDR_BITS-1:0] range_low;
    logic [ADDR_BITS-1:0] range_high;
  } arst_in_t;

  // result transaction
  typedef struct packed {
    logic             found;
    logic             status;
    logic [CNT_W-1:0] used_entries;
  } arst_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit1;
    logic             commit2;
    logic             out_load;
  } arst_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic noop;
    logic need_second;
  } arst_sts_t;

endpackage

### sv/arst_ctrl.sv
// sequencer: walks the table slots and orders the commit and result steps
module arst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output arst_pkg::arst_cmd_t cmd,
  input  arst_pkg::arst_sts_t sts
);
  import arst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_WALK, S_DRAIN, S_COMMIT1, S_COMMIT2, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.rd_addr   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        idx_nxt   = '0;
        state_nxt = sts.noop ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT1;
      end
      S_COMMIT1: begin
        cmd.commit1 = 1'b1;
        state_nxt   = sts.need_second ? S_COMMIT2 : S_DONE;
      end
      S_COMMIT2: begin
        cmd.commit2 = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // result register must be free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/arst_dp.sv
// datapath: range table memory, valid bits, shared slot comparator, result register
module arst_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  arst_pkg::arst_cmd_t cmd,
  output arst_pkg::arst_sts_t sts,
  input  arst_pkg::arst_in_t  in_data,
  output arst_pkg::arst_out_t out_data
);
  import arst_pkg::*;

  // range bound memories
  logic [ADDR_BITS-1:0] mem_lo [ENTRIES];
  logic [ADDR_BITS-1:0] mem_hi [ENTRIES];
  logic [ADDR_BITS-1:0] rd_lo_r, rd_hi_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;

  // operation registers
  logic [OP_W-1:0]      op_r;
  logic [ADDR_BITS-1:0] lo_r, hi_r, lo_m1_r, hi_p1_r;
  logic                 lo_zero_r, hi_max_r, noop_r;

  // walk accumulators
  logic [ADDR_BITS-1:0] acc_lo_r, acc_hi_r, split_hi_r;
  logic                 found_r, status_r, free_found_r, contain_r;
  logic [IDX_W-1:0]     free_idx_r, split_idx_r;

  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  arst_out_t            out_r;

  // load decode
  logic [ADDR_BITS-1:0] ld_lo, ld_hi;
  logic                 ld_noop;

  // slot compare
  logic slot_v, ovl, touch, below, above, contain, free_cand;

  // memory write port
  logic                 we_lo, we_hi;
  logic [IDX_W-1:0]     waddr;
  logic [ADDR_BITS-1:0] wd_lo, wd_hi;

  assign sts.noop        = noop_r;
  assign sts.need_second = (op_r == OP_SUB) && contain_r && free_found_r;
  assign out_data        = out_r;

  // operand decode at load
  always_comb begin
    ld_lo = in_data.range_low;
    ld_hi = (in_data.opcode == OP_TEST_VAL) ? in_data.range_low : in_data.range_high;
    case (in_data.opcode)
      OP_ADD, OP_SUB, OP_TEST_RNG: ld_noop = (ld_lo > ld_hi);
      OP_TEST_VAL:                 ld_noop = 1'b0;
      default:                     ld_noop = 1'b1;
    endcase
  end

  // one slot against the operation range
  always_comb begin
    slot_v  = valid_r[cmp_idx_r];
    ovl     = (hi_r >= rd_lo_r) && (lo_r <= rd_hi_r);
    touch   = (hi_max_r || (hi_p1_r >= rd_lo_r)) && (lo_zero_r || (lo_m1_r <= rd_hi_r));
    below   = (rd_lo_r < lo_r);
    above   = (rd_hi_r > hi_r);
    contain = below && above;
    case (op_r)
      OP_ADD:  free_cand = !slot_v || touch;
      default: free_cand = !slot_v;
    endcase
  end

  // table writes, valid bits and entry count
  always_comb begin
    we_lo     = 1'b0;
    we_hi     = 1'b0;
    waddr     = cmp_idx_r;
    wd_lo     = hi_p1_r;
    wd_hi     = lo_m1_r;
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (cmd.load && (in_data.opcode == OP_CLEAR)) begin
      valid_nxt = '0;
      cnt_nxt   = '0;
    end
    // walk step: merge or trim this slot
    if (cmp_vld_r && slot_v) begin
      case (op_r)
        OP_ADD: begin
          if (touch) begin
            valid_nxt[cmp_idx_r] = 1'b0;
            cnt_nxt              = cnt_r - CNT_W'(1);
          end
        end
        OP_SUB: begin
          if (ovl && !contain) begin
            if (!below && !above) begin
              valid_nxt[cmp_idx_r] = 1'b0;
              cnt_nxt              = cnt_r - CNT_W'(1);
            end else if (below) begin
              we_hi = 1'b1;
            end else begin
              we_lo = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // first commit: merged range, or lower half of a split
    if (cmd.commit1 && free_found_r) begin
      case (op_r)
        OP_ADD: begin
          waddr              = free_idx_r;
          we_lo              = 1'b1;
          we_hi              = 1'b1;
          wd_lo              = acc_lo_r;
          wd_hi              = acc_hi_r;
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt            = cnt_r + CNT_W'(1);
        end
        OP_SUB: begin
          if (contain_r) begin
            waddr = split_idx_r;
            we_hi = 1'b1;
            wd_hi = lo_m1_r;
          end
        end
        default: begin
        end
      endcase
    end
    // second commit: upper half of a split into the free slot
    if (cmd.commit2) begin
      waddr                 = free_idx_r;
      we_lo                 = 1'b1;
      we_hi                 = 1'b1;
      wd_lo                 = hi_p1_r;
      wd_hi                 = split_hi_r;
      valid_nxt[free_idx_r] = 1'b1;
      cnt_nxt               = cnt_r + CNT_W'(1);
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_lo[waddr] <= wd_lo;
    end
    if (we_hi) begin
      mem_hi[waddr] <= wd_hi;
    end
    if (cmd.rd_en) begin
      rd_lo_r <= mem_lo[cmd.rd_addr];
      rd_hi_r <= mem_hi[cmd.rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmd.rd_en;
    end
  end

  // operation and accumulator registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.rd_addr;
    if (cmd.load) begin
      op_r         <= in_data.opcode;
      lo_r         <= ld_lo;
      hi_r         <= ld_hi;
      lo_m1_r      <= ld_lo - ADDR_BITS'(1);
      hi_p1_r      <= ld_hi + ADDR_BITS'(1);
      lo_zero_r    <= (ld_lo == '0);
      hi_max_r     <= &ld_hi;
      noop_r       <= ld_noop;
      acc_lo_r     <= ld_lo;
      acc_hi_r     <= ld_hi;
      found_r      <= 1'b0;
      status_r     <= 1'b0;
      free_found_r <= 1'b0;
      contain_r    <= 1'b0;
    end
    if (cmp_vld_r) begin
      if (free_cand && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (slot_v) begin
        case (op_r)
          OP_ADD: begin
            if (touch && below) acc_lo_r <= rd_lo_r;
            if (touch && above) acc_hi_r <= rd_hi_r;
          end
          OP_SUB: begin
            if (contain) begin
              contain_r   <= 1'b1;
              split_idx_r <= cmp_idx_r;
              split_hi_r  <= rd_hi_r;
            end
          end
          OP_TEST_VAL, OP_TEST_RNG: begin
            if (ovl) found_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    // no free slot for a new or split range
    if (cmd.commit1 && !free_found_r &&
        ((op_r == OP_ADD) || ((op_r == OP_SUB) && contain_r))) begin
      status_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_r.found        <= found_r;
      out_r.status       <= status_r;
      out_r.used_entries <= cnt_r;
    end
  end

endmodule

### sv/address_range_set_table_unit.sv
// Address range set table, top level.
// Sequence: load, prepare, walk every table slot, drain the last read, first commit,
// a second commit for a split, then the result; clear, unknown opcodes and empty ranges
// skip from prepare to the result. One transaction at a time, walked through the single
// table read port; a held result stalls the sequencer until it is taken.
// Reset: valid bits and entry count cleared at once; range bounds undefined, no sweep.
module address_range_set_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  arst_pkg::arst_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output arst_pkg::arst_out_t out_data
);
  import arst_pkg::*;

  arst_cmd_t cmd;
  arst_sts_t sts;

  // sequencer
  arst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table and compare datapath
  arst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### sv/arst_chk.sv
// port-level checker for the address range set table, bound to the top level
`include "assert_macros.svh"

module arst_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input arst_pkg::arst_out_t out_data
);
  import arst_pkg::*;

  // a waiting result holds until taken
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped before accept")
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "stalled result changed")
  // no result directly out of reset
  `ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")
  // one transaction at a time in the table walk
  `ASSERT_CLK(a_one_busy, in_valid && in_ready |=> !in_ready, "input taken while busy")
  // a full table never comes with a hit
  `ASSERT_CLK(a_full_no_hit, out_valid && out_data.status |-> !out_data.found, "full with found")

endmodule

bind address_range_set_table_unit arst_chk u_arst_chk (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the address range set table with a built-in set predictor
module tb_top;
  import arst_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RST_CYCLES = 5;
  localparam int RAND_ITEMS = 1700;
  localparam int QUIET_TAIL = 300;
  localparam int DRAIN_CYCLES = 3 * (ENTRIES + 6);
  localparam int HANG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;
  localparam logic [ADDR_BITS-1:0] ADDR_ONE = ADDR_BITS'(1);

  // opcodes the block treats as no operation
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct {
    arst_in_t  item;
    bit        known;
    arst_out_t typed;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  arst_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  arst_out_t out_data;

  // predicted contents of the range table
  logic [ADDR_BITS-1:0] set_lo [ENTRIES];
  logic [ADDR_BITS-1:0] set_hi [ENTRIES];
  logic [ENTRIES-1:0]   set_vld;

  arst_out_t pending_results[$];
  dir_row_t  op_table[$];
  int        mismatches = 0;
  int        hang_cycles = 0;
  bit        stall_en = 1'b0;

  address_range_set_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // first unused slot, or -1 when the table is full
  function automatic int first_free();
    for (int s = 0; s < ENTRIES; s++) begin
      if (!set_vld[s]) return s;
    end
    return -1;
  endfunction

  // applies one operation to the predicted set and returns the expected result
  function automatic arst_out_t apply_set_op(arst_in_t t);
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    arst_out_t            r;
    bit                   merged;
    bit                   again;
    bit                   split_seen;
    int                   fs;
    int                   cnt;
    lo = t.range_low;
    hi = t.range_high;
    r = '0;
    case (t.opcode)
      OP_CLEAR: begin
        set_vld = '0;
      end
      OP_ADD: begin
        if (lo <= hi) begin
          // absorb every range that overlaps or touches, no wrap at the ends
          merged = 1'b0;
          again = 1'b1;
          while (again) begin
            again = 1'b0;
            for (int s = 0; s < ENTRIES; s++) begin
              if (set_vld[s] && (hi == ADDR_TOP || hi + ADDR_ONE >= set_lo[s]) &&
                  (lo == '0 || lo - ADDR_ONE <= set_hi[s])) begin
                if (set_lo[s] < lo) lo = set_lo[s];
                if (set_hi[s] > hi) hi = set_hi[s];
                set_vld[s] = 1'b0;
                merged = 1'b1;
                again = 1'b1;
              end
            end
          end
          fs = first_free();
          if (fs < 0) begin
            r.status = 1'b1;
          end else begin
            set_lo[fs] = lo;
            set_hi[fs] = hi;
            set_vld[fs] = 1'b1;
          end
        end
      end
      OP_SUB: begin
        if (lo <= hi) begin
          // a hole strictly inside one range needs a second slot
          split_seen = 1'b0;
          for (int s = 0; s < ENTRIES; s++) begin
            if (!split_seen && set_vld[s] && set_lo[s] < lo && set_hi[s] > hi) begin
              split_seen = 1'b1;
              fs = first_free();
              if (fs < 0) begin
                r.status = 1'b1;
              end else begin
                set_lo[fs] = hi + ADDR_ONE;
                set_hi[fs] = set_hi[s];
                set_vld[fs] = 1'b1;
                set_hi[s] = lo - ADDR_ONE;
              end
            end
          end
          // otherwise trim or drop every overlapped range
          if (!split_seen) begin
            for (int s = 0; s < ENTRIES; s++) begin
              if (set_vld[s] && hi >= set_lo[s] && lo <= set_hi[s]) begin
                if (set_lo[s] >= lo && set_hi[s] <= hi) set_vld[s] = 1'b0;
                else if (set_lo[s] < lo) set_hi[s] = lo - ADDR_ONE;
                else set_lo[s] = hi + ADDR_ONE;
              end
            end
          end
        end
      end
      OP_TEST_VAL: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (set_vld[s] && lo >= set_lo[s] && lo <= set_hi[s]) r.found = 1'b1;
        end
      end
      OP_TEST_RNG: begin
        if (lo <= hi) begin
          for (int s = 0; s < ENTRIES; s++) begin
            if (set_vld[s] && hi >= set_lo[s] && lo <= set_hi[s]) r.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    cnt = 0;
    for (int s = 0; s < ENTRIES; s++) begin
      if (set_vld[s]) cnt++;
    end
    r.used_entries = CNT_W'(cnt);
    return r;
  endfunction

  function automatic dir_row_t row(logic [OP_W-1:0] op, logic [ADDR_BITS-1:0] lo,
                                   logic [ADDR_BITS-1:0] hi, int known, int f,
                                   int st, int used);
    dir_row_t d;
    d.item.opcode = op;
    d.item.range_low = lo;
    d.item.range_high = hi;
    d.known = (known != 0);
    d.typed.found = (f != 0);
    d.typed.status = (st != 0);
    d.typed.used_entries = CNT_W'(used);
    return d;
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%t  %s", $realtime, msg);
  endfunction

  // drive one transaction, predict it once accepted; returns at a falling edge
  task automatic send_op(arst_in_t item, bit known, arst_out_t typed);
    arst_out_t want;
    if (stall_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = apply_set_op(item);
    pending_results.push_back(known ? typed : want);
    @(negedge clk);
  endtask

  // random address window so that ranges collide, merge and fill the table
  task automatic pick_window(output logic [ADDR_BITS-1:0] base);
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = ADDR_TOP - ADDR_BITS'(511);
      default: begin
        base = ADDR_BITS'({$urandom, $urandom});
        if (base > ADDR_TOP - ADDR_BITS'(511)) base = ADDR_TOP - ADDR_BITS'(511);
      end
    endcase
  endtask

  // result side stalls
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 4) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    arst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result found=%0b status=%0b used=%0d",
                             out_data.found, out_data.status, out_data.used_entries));
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found || out_data.status !== want.status ||
            out_data.used_entries !== want.used_entries) begin
          note_error($sformatf(
            "result mismatch: exp found=%0b status=%0b used=%0d, got found=%0b status=%0b used=%0d",
            want.found, want.status, want.used_entries,
            out_data.found, out_data.status, out_data.used_entries));
        end
      end
    end
  end

  // hang detection: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        hang_cycles <= 0;
      end else if (hang_cycles + 1 >= HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    logic [ADDR_BITS-1:0] tmp;
    arst_in_t             item;
    int                   pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    set_vld = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty set, address ends, empty ranges, split, no-op codes
    op_table.push_back(row(OP_TEST_VAL, '0, '0, 1, 0, 0, 0));
    op_table.push_back(row(OP_ADD, '0, '0, 1, 0, 0, 1));
    op_table.push_back(row(OP_ADD, ADDR_TOP, ADDR_TOP, 1, 0, 0, 2));
    op_table.push_back(row(OP_ADD, ADDR_ONE, ADDR_TOP - ADDR_ONE, 1, 0, 0, 1));
    op_table.push_back(row(OP_TEST_VAL, ADDR_TOP, '0, 1, 1, 0, 1));
    op_table.push_back(row(OP_TEST_RNG, ADDR_TOP, '0, 1, 0, 0, 1));
    op_table.push_back(row(OP_ADD, ADDR_BITS'(9), ADDR_BITS'(3), 1, 0, 0, 1));
    op_table.push_back(row(OP_SUB, ADDR_BITS'(10), ADDR_BITS'(20), 0, 0, 0, 0));
    op_table.push_back(row(OP_TEST_RNG, ADDR_BITS'(10), ADDR_BITS'(20), 0, 0, 0, 0));
    op_table.push_back(row(OP_SUB, '0, '0, 0, 0, 0, 0));
    op_table.push_back(row(OP_RSVD_FIRST, ADDR_TOP, ADDR_TOP, 1, 0, 0, 2));
    op_table.push_back(row(OP_CLEAR, '0, '0, 1, 0, 0, 0));
    // fill every slot, then an insert and a split that find no room
    for (int k = 0; k < ENTRIES; k++) begin
      op_table.push_back(row(OP_ADD, ADDR_BITS'(4 * k), ADDR_BITS'(4 * k + 2), 0, 0, 0, 0));
    end
    op_table.push_back(row(OP_ADD, ADDR_BITS'(1000), ADDR_BITS'(1000), 1, 0, 1, ENTRIES));
    op_table.push_back(row(OP_SUB, ADDR_ONE, ADDR_ONE, 1, 0, 1, ENTRIES));
    op_table.push_back(row(OP_ADD, ADDR_BITS'(3), ADDR_BITS'(3), 0, 0, 0, 0));

    stall_en = 1'b1;
    foreach (op_table[i]) send_op(op_table[i].item, op_table[i].known, op_table[i].typed);

    // random: clustered ranges in a moving window, some wide and empty ones
    base = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        pick_window(base);
        stall_en = (n < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) item.opcode = OP_CLEAR;
      else if (pick < 44) item.opcode = OP_ADD;
      else if (pick < 66) item.opcode = OP_SUB;
      else if (pick < 80) item.opcode = OP_TEST_VAL;
      else if (pick < 97) item.opcode = OP_TEST_RNG;
      else item.opcode = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        lo = ADDR_BITS'({$urandom, $urandom});
        hi = ADDR_BITS'({$urandom, $urandom});
      end else begin
        lo = base + ADDR_BITS'($urandom_range(0, 447));
        hi = lo + ADDR_BITS'($urandom_range(0, (pick < 30) ? 64 : 8));
        if (pick < 15) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
      item.range_low = lo;
      item.range_high = hi;
      send_op(item, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
